[src/ipat_pkg.sv]
// Package for the IP address to text unit: status and family codes, mode type,
// character constants and the digit helper functions. No dependencies.
`default_nettype none

package ipat_pkg;

	localparam int unsigned NUM_GROUPS = 8;
	localparam logic [7:0] MIN_SIZE_V4 = 8'd16;
	localparam logic [7:0] MIN_SIZE_V6 = 8'd46;

	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_DOT = 8'h2E;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_HEX_ALPHA_BASE = 8'h57;

	typedef enum logic [1:0] {
		FAM_IPV4 = 2'd0,
		FAM_IPV6 = 2'd1,
		FAM_RSVD2 = 2'd2,
		FAM_RSVD3 = 2'd3
	} family_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_NO_SPACE = 2'd1,
		ST_BAD_FAMILY = 2'd2,
		ST_SIZE_ZERO = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		MODE_STATUS = 2'd0,
		MODE_V4 = 2'd1,
		MODE_V6 = 2'd2
	} mode_t;

	// Lower-case ASCII hex digit for one nibble.
	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		logic [7:0] n8;
		n8 = {4'h0, nib};
		if (nib < 4'd10) begin
			return CH_ZERO + n8;
		end
		return CH_HEX_ALPHA_BASE + n8;
	endfunction

	// Three BCD digits of a byte: {hundreds, tens, ones}.
	function automatic logic [11:0] dec_digits(input logic [7:0] v);
		logic [1:0] h;
		logic [7:0] r;
		logic [15:0] m;
		logic [3:0] t;
		logic [7:0] o;
		if (v >= 8'd200) begin
			h = 2'd2;
			r = v - 8'd200;
		end else if (v >= 8'd100) begin
			h = 2'd1;
			r = v - 8'd100;
		end else begin
			h = 2'd0;
			r = v;
		end
		// tens = r * 205 >> 11, exact for r below 100
		m = {8'h00, r} * 16'd205;
		t = m[14:11];
		o = r - ({4'h0, t} * 8'd10);
		return {2'b00, h, t, o[3:0]};
	endfunction

endpackage

`default_nettype wire

[src/ipat_in_if.sv]
// Address channel of the IP address to text unit: valid/ready plus item fields.
// Depends on nothing.
`default_nettype none

interface ipat_in_if;
	logic valid;
	logic ready;
	logic [1:0] cmd;
	logic [63:0] addr_hi;
	logic [63:0] addr_lo;
	logic [7:0] buf_size;

	modport source (output valid, output cmd, output addr_hi, output addr_lo,
		output buf_size, input ready);
	modport sink (input valid, input cmd, input addr_hi, input addr_lo,
		input buf_size, output ready);
endinterface

`default_nettype wire

[src/ipat_out_if.sv]
// Text channel of the IP address to text unit: valid/ready plus one character item.
// Depends on nothing.
`default_nettype none

interface ipat_out_if;
	logic valid;
	logic ready;
	logic [7:0] text_char;
	logic char_valid;
	logic [1:0] status;
	logic last;

	modport source (output valid, output text_char, output char_valid,
		output status, output last, input ready);
	modport sink (input valid, input text_char, input char_valid,
		input status, input last, output ready);
endinterface

`default_nettype wire

[src/ip_address_to_text_unit.sv]
// Top level: binary IPv4/IPv6 address to ASCII text, one character per item.
// Depends on ipat_pkg, ipat_in_if and ipat_out_if.
//
//  channel   dir  modport  items per address
//  addr_ch   in   sink     1 (cmd, addr_hi, addr_lo, buf_size)
//  text_ch   out  source   1 to 39 (text_char, char_valid, status, last)
//
// One text item leaves per cycle from the output register while text_ch does not
// stall; an address gives as many items as it has characters (1 for a status-only
// item, 7..15 for IPv4, 2..39 for IPv6), set by the single character cursor.
// The next address is taken in the cycle its predecessor's last item is loaded.
// arst_n clears the busy flag and the output valid; no clearing pass.
// A stall on text_ch holds the output register and the cursor.
`default_nettype none

module ip_address_to_text_unit (
	input wire logic clk,
	input wire logic arst_n,
	ipat_in_if.sink addr_ch,
	ipat_out_if.source text_ch
);

	logic busy_q;
	ipat_pkg::mode_t mode_q;
	ipat_pkg::status_t status_q;
	logic [63:0] addr_hi_q;
	logic [63:0] addr_lo_q;
	logic [2:0] grp_q;
	logic [2:0] pos_q;

	logic out_valid_q;
	logic [7:0] text_char_q;
	logic char_valid_q;
	logic [1:0] status_out_q;
	logic last_q;

	logic emit;
	logic accept;
	logic in_ready;
	ipat_pkg::status_t new_status;
	ipat_pkg::mode_t new_mode;

	logic [127:0] addr_all;
	logic [15:0] grp_val [ipat_pkg::NUM_GROUPS];
	logic [ipat_pkg::NUM_GROUPS-1:0] zero_vec;
	logic has_z;
	logic [2:0] z_idx;
	logic [3:0] e_idx;

	logic [15:0] cur_grp;
	logic [2:0] n6;
	logic [2:0] sep6;
	logic [2:0] dig6;
	logic [2:0] len6;
	logic [2:0] idx6;
	logic [3:0] nib6;
	logic [3:0] next6;
	logic [7:0] char6;

	logic [7:0] cur_byte;
	logic [11:0] bcd;
	logic [2:0] n4;
	logic [2:0] len4;
	logic [2:0] idx4;
	logic [3:0] dig4;
	logic [7:0] char4;

	logic tok_end;
	logic cur_last;
	logic [3:0] next_grp;
	logic [7:0] cur_char;
	logic cur_char_valid;

	// Input item classification
	always_comb begin
		if (addr_ch.buf_size == 8'd0) begin
			new_status = ipat_pkg::ST_SIZE_ZERO;
		end else begin
			case (ipat_pkg::family_t'(addr_ch.cmd))
				ipat_pkg::FAM_IPV4: new_status = (addr_ch.buf_size < ipat_pkg::MIN_SIZE_V4)
					? ipat_pkg::ST_NO_SPACE : ipat_pkg::ST_OK;
				ipat_pkg::FAM_IPV6: new_status = (addr_ch.buf_size < ipat_pkg::MIN_SIZE_V6)
					? ipat_pkg::ST_NO_SPACE : ipat_pkg::ST_OK;
				default: new_status = ipat_pkg::ST_BAD_FAMILY;
			endcase
		end
		if (new_status != ipat_pkg::ST_OK) begin
			new_mode = ipat_pkg::MODE_STATUS;
		end else if (addr_ch.cmd == ipat_pkg::FAM_IPV4) begin
			new_mode = ipat_pkg::MODE_V4;
		end else begin
			new_mode = ipat_pkg::MODE_V6;
		end
	end

	// IPv6 groups and the first zero run
	assign addr_all = {addr_hi_q, addr_lo_q};

	always_comb begin
		for (int g = 0; g < ipat_pkg::NUM_GROUPS; g++) begin
			grp_val[g] = addr_all[127 - 16*g -: 16];
			zero_vec[g] = (grp_val[g] == 16'h0000);
		end
		has_z = |zero_vec;
		z_idx = 3'd0;
		for (int g = ipat_pkg::NUM_GROUPS - 1; g >= 0; g--) begin
			if (zero_vec[g]) begin
				z_idx = 3'(g);
			end
		end
		e_idx = 4'(ipat_pkg::NUM_GROUPS);
		for (int g = ipat_pkg::NUM_GROUPS - 1; g >= 0; g--) begin
			if (!zero_vec[g] && (g > int'(z_idx))) begin
				e_idx = 4'(g);
			end
		end
	end

	// IPv6 character at the cursor
	always_comb begin
		cur_grp = grp_val[grp_q];
		if (cur_grp[15:12] != 4'h0) begin
			n6 = 3'd4;
		end else if (cur_grp[11:8] != 4'h0) begin
			n6 = 3'd3;
		end else if (cur_grp[7:4] != 4'h0) begin
			n6 = 3'd2;
		end else begin
			n6 = 3'd1;
		end
		if (has_z && (grp_q == z_idx)) begin
			sep6 = 3'd2;
			dig6 = 3'd0;
			next6 = e_idx;
		end else begin
			sep6 = ((grp_q == 3'd0) || (has_z && ({1'b0, grp_q} == e_idx))) ? 3'd0 : 3'd1;
			dig6 = n6;
			next6 = {1'b0, grp_q} + 4'd1;
		end
		len6 = sep6 + dig6;
		idx6 = (3'd4 - n6) + (pos_q - sep6);
		case (idx6[1:0])
			2'd0: nib6 = cur_grp[15:12];
			2'd1: nib6 = cur_grp[11:8];
			2'd2: nib6 = cur_grp[7:4];
			default: nib6 = cur_grp[3:0];
		endcase
		char6 = (pos_q < sep6) ? ipat_pkg::CH_COLON : ipat_pkg::hex_char(nib6);
	end

	// IPv4 character at the cursor
	always_comb begin
		case (grp_q[1:0])
			2'd0: cur_byte = addr_hi_q[63:56];
			2'd1: cur_byte = addr_hi_q[55:48];
			2'd2: cur_byte = addr_hi_q[47:40];
			default: cur_byte = addr_hi_q[39:32];
		endcase
		bcd = ipat_pkg::dec_digits(cur_byte);
		if (bcd[11:8] != 4'h0) begin
			n4 = 3'd3;
		end else if (bcd[7:4] != 4'h0) begin
			n4 = 3'd2;
		end else begin
			n4 = 3'd1;
		end
		len4 = n4 + ((grp_q[1:0] != 2'd3) ? 3'd1 : 3'd0);
		idx4 = (3'd3 - n4) + pos_q;
		case (idx4[1:0])
			2'd0: dig4 = bcd[11:8];
			2'd1: dig4 = bcd[7:4];
			default: dig4 = bcd[3:0];
		endcase
		char4 = (pos_q < n4) ? (ipat_pkg::CH_ZERO + {4'h0, dig4}) : ipat_pkg::CH_DOT;
	end

	// Mode select
	always_comb begin
		unique case (mode_q)
			ipat_pkg::MODE_V4: begin
				tok_end = (pos_q == (len4 - 3'd1));
				next_grp = {1'b0, grp_q} + 4'd1;
				cur_last = tok_end && (grp_q[1:0] == 2'd3);
				cur_char = char4;
				cur_char_valid = 1'b1;
			end
			ipat_pkg::MODE_V6: begin
				tok_end = (pos_q == (len6 - 3'd1));
				next_grp = next6;
				cur_last = tok_end && (next6 == 4'(ipat_pkg::NUM_GROUPS));
				cur_char = char6;
				cur_char_valid = 1'b1;
			end
			default: begin
				tok_end = 1'b1;
				next_grp = 4'd0;
				cur_last = 1'b1;
				cur_char = 8'h00;
				cur_char_valid = 1'b0;
			end
		endcase
	end

	assign emit = busy_q && (!out_valid_q || text_ch.ready);
	assign in_ready = !busy_q || (emit && cur_last);
	assign accept = addr_ch.valid && in_ready;
	assign addr_ch.ready = in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			mode_q <= ipat_pkg::MODE_STATUS;
			status_q <= ipat_pkg::ST_OK;
			grp_q <= 3'd0;
			pos_q <= 3'd0;
		end else if (accept) begin
			busy_q <= 1'b1;
			mode_q <= new_mode;
			status_q <= new_status;
			grp_q <= 3'd0;
			pos_q <= 3'd0;
		end else if (emit) begin
			if (cur_last) begin
				busy_q <= 1'b0;
			end
			if (tok_end) begin
				grp_q <= next_grp[2:0];
				pos_q <= 3'd0;
			end else begin
				pos_q <= pos_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			addr_hi_q <= addr_ch.addr_hi;
			addr_lo_q <= addr_ch.addr_lo;
		end
		if (emit) begin
			text_char_q <= cur_char;
			char_valid_q <= cur_char_valid;
			status_out_q <= status_q;
			last_q <= cur_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (text_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign text_ch.valid = out_valid_q;
	assign text_ch.text_char = text_char_q;
	assign text_ch.char_valid = char_valid_q;
	assign text_ch.status = status_out_q;
	assign text_ch.last = last_q;

	a_status_only_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !char_valid_q) |-> (last_q && (status_out_q != ipat_pkg::ST_OK)))
		else $error("status-only item without last or with ok status");

	a_char_is_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && char_valid_q) |-> (status_out_q == ipat_pkg::ST_OK))
		else $error("character item with nonzero status");

	a_accept_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> (!busy_q || (emit && cur_last)))
		else $error("address taken while previous one still has characters");

	a_busy_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && !cur_last) |=> busy_q)
		else $error("busy dropped before last character");

	a_emit_fills_output: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> out_valid_q)
		else $error("emitted character not held in output register");

endmodule

`default_nettype wire
